// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while reset is asserted.
`define BPR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error(msg);

// Concurrent check that also runs through reset.
`define BPR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/bpr_pkg.sv -----
`timescale 1ns / 1ps

package bpr_pkg;

    localparam int DEPTH_DEFAULT = 256;

    localparam int ACTION_W = 2;
    localparam int BYTE_W   = 8;
    localparam int FILL_W   = 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUT_BYTE    = 2'd0,
        ACT_PUT_BIT     = 2'd1,
        ACT_GET_BYTE    = 2'd2,
        ACT_CLEAR_ERROR = 2'd3
    } t_action;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } t_state;

endpackage

// ----- rtl/bpr_in_if.sv -----
`timescale 1ns / 1ps

interface bpr_in_if;
    import bpr_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   data_byte;
    logic                bit_value;

    modport source (output valid, action, data_byte, bit_value, input ready);
    modport sink   (input valid, action, data_byte, bit_value, output ready);
endinterface

// ----- rtl/bpr_out_if.sv -----
`timescale 1ns / 1ps

interface bpr_out_if;
    import bpr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_data;
    logic              error_flag;
    logic [FILL_W-1:0] fill_level;

    modport source (output valid, read_data, error_flag, fill_level, input ready);
    modport sink   (input valid, read_data, error_flag, fill_level, output ready);
endinterface

// ----- rtl/bit_packing_ring_fifo_unit.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Fields                                  Transfer
// i_in      in   action, data_byte, bit_value            valid & ready
// o_out     out  read_data, error_flag, fill_level       valid & ready
//
// One result per input item, registered from the item; a get_byte that reads
// waits in ST_READ for the byte store's registered read data.
// Reset is synchronous, active low; indexes, bit packer and error flag clear
// at once, the byte store is not cleared and needs no sweep.
// A stalled result blocks new items only once the output register is full.

module bit_packing_ring_fifo_unit #(
    parameter int DEPTH = bpr_pkg::DEPTH_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bpr_in_if.sink    i_in,
    bpr_out_if.source o_out
);
    import bpr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int XW = (AW + 1 > FILL_W) ? AW + 1 : FILL_W;
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    logic [BYTE_W-1:0] r_store [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_wr_idx, n_wr_idx;
    logic [AW-1:0]     r_rd_idx, n_rd_idx;
    logic [2:0]        r_bit_pos, n_bit_pos;
    logic [BYTE_W-1:0] r_partial, n_partial;
    logic              r_err, n_err;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_data;
    logic              r_out_err;
    logic [FILL_W-1:0] r_out_fill;

    t_action           act;
    logic              in_ready;
    logic              accept;
    logic [AW-1:0]     wr_step, rd_step;
    logic              full, empty;
    logic              wr_en, rd_en;
    logic [BYTE_W-1:0] wr_data;
    logic [BYTE_W-1:0] packed_byte;
    logic [XW-1:0]     fill_ext;

    assign act     = t_action'(i_in.action);
    assign wr_step = (r_wr_idx == LAST_SLOT) ? '0 : r_wr_idx + 1'b1;
    assign rd_step = (r_rd_idx == LAST_SLOT) ? '0 : r_rd_idx + 1'b1;
    assign full    = (wr_step == r_rd_idx);
    assign empty   = (r_wr_idx == r_rd_idx);
    assign accept  = i_in.valid & in_ready;
    assign packed_byte = r_partial
                       | (i_in.bit_value ? (BYTE_W'(1) << r_bit_pos) : '0);

    always_comb begin
        n_wr_idx  = r_wr_idx;
        n_rd_idx  = r_rd_idx;
        n_bit_pos = r_bit_pos;
        n_partial = r_partial;
        n_err     = r_err;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        wr_data   = i_in.data_byte;
        if (accept) begin
            case (act)
                ACT_PUT_BYTE: begin
                    if (full) begin
                        n_err = 1'b1;
                    end else begin
                        wr_en     = 1'b1;
                        n_wr_idx  = wr_step;
                        n_partial = '0;
                    end
                end
                ACT_PUT_BIT: begin
                    if (full) begin
                        n_err = 1'b1;
                    end else if (r_bit_pos == 3'd7) begin
                        wr_en     = 1'b1;
                        wr_data   = packed_byte;
                        n_wr_idx  = wr_step;
                        n_partial = '0;
                        n_bit_pos = '0;
                    end else begin
                        n_partial = packed_byte;
                        n_bit_pos = r_bit_pos + 3'd1;
                    end
                end
                ACT_GET_BYTE: begin
                    if (empty) begin
                        n_err = 1'b1;
                    end else begin
                        rd_en    = 1'b1;
                        n_rd_idx = rd_step;
                    end
                end
                ACT_CLEAR_ERROR: n_err = 1'b0;
                default: n_err = r_err;
            endcase
        end
    end

    // Committed bytes after this item, modulo DEPTH
    assign fill_ext = XW'(n_wr_idx) - XW'(n_rd_idx)
                    + ((n_wr_idx < n_rd_idx) ? XW'(DEPTH) : '0);

    // Reads only touch committed slots and writes only the free slot,
    // so a read and a write never hit the same entry.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[r_wr_idx] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_store[r_rd_idx];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (accept && rd_en) n_state = ST_READ;
            ST_READ: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        case (r_state)
            ST_IDLE: in_ready = !r_out_valid || o_out.ready;
            default: in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_wr_idx  <= '0;
            r_rd_idx  <= '0;
            r_bit_pos <= '0;
            r_partial <= '0;
            r_err     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wr_idx  <= n_wr_idx;
            r_rd_idx  <= n_rd_idx;
            r_bit_pos <= n_bit_pos;
            r_partial <= n_partial;
            r_err     <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            // a get that reads raises valid from ST_READ, after the store's registered read
            r_out_valid <= !rd_en;
        end else if (r_state == ST_READ) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= '0;
            r_out_err  <= n_err;
            r_out_fill <= fill_ext[FILL_W-1:0];
        end else if (r_state == ST_READ) begin
            r_out_data <= r_rd_data;
        end
    end

    assign i_in.ready       = in_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.read_data  = r_out_data;
    assign o_out.error_flag = r_out_err;
    assign o_out.fill_level = r_out_fill;

endmodule

// ----- rtl/bpr_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bpr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_in_action,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_read_data,
    input logic       i_out_error_flag,
    input logic [7:0] i_out_fill_level
);
    import bpr_pkg::*;

    logic in_xfer;
    assign in_xfer = i_in_valid && i_in_ready;

    `BPR_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

    `BPR_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_read_data) && $stable(i_out_error_flag) && $stable(i_out_fill_level), "stalled result changed")

    `BPR_ASSERT(a_stall_blocks_in, i_clk, i_rst_n, i_out_valid && !i_out_ready |-> !i_in_ready, "input taken while result register full")

    `BPR_ASSERT(a_clear_result, i_clk, i_rst_n, in_xfer && i_in_action == ACT_CLEAR_ERROR |=> i_out_valid && !i_out_error_flag, "clear_error result wrong")

    `BPR_ASSERT(a_put_reads_zero, i_clk, i_rst_n, in_xfer && i_in_action != ACT_GET_BYTE |=> i_out_valid && i_out_read_data == 8'd0, "non-get result late or nonzero")

endmodule

bind bit_packing_ring_fifo_unit bpr_checker u_bpr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_in_action      (i_in.action),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_read_data  (o_out.read_data),
    .i_out_error_flag (o_out.error_flag),
    .i_out_fill_level (o_out.fill_level)
);
